/* rtl/core/dfe_pkg.sv */
// shared types, constants and the word expansion function for the display frame engine
// depends on nothing; used by dfe_front, dfe_jobq, dfe_back and the top level
package dfe_pkg;

	// command codes on the input side
	localparam logic [1:0] CMD_WR_START = 2'd0;
	localparam logic [1:0] CMD_WR_BYTE  = 2'd1;
	localparam logic [1:0] CMD_RD_START = 2'd2;
	localparam logic [1:0] CMD_REPLY    = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_TX    = 2'd0;
	localparam logic [1:0] KIND_RX    = 2'd1;
	localparam logic [1:0] KIND_WDONE = 2'd2;
	localparam logic [1:0] KIND_RDONE = 2'd3;

	// done status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_ACK  = 2'd1;
	localparam logic [1:0] ST_BAD_SOF = 2'd2;
	localparam logic [1:0] ST_BAD_SUM = 2'd3;

	// link bytes
	localparam logic [7:0] B_ACK    = 8'h06;
	localparam logic [7:0] B_DC1    = 8'h11;
	localparam logic [7:0] B_DC2    = 8'h12;
	localparam logic [7:0] B_ESC    = 8'h1B;
	localparam logic [7:0] B_ONE    = 8'h01;
	localparam logic [7:0] B_RD_CMD = 8'h53;
	localparam logic [7:0] B_DUMMY  = 8'h00;
	localparam logic [7:0] B_RD_SUM = 8'h66;

	// front state, one-hot
	typedef enum logic [7:0] {
		PH_IDLE   = 8'b0000_0001,
		PH_WPAY   = 8'b0000_0010,
		PH_WACK   = 8'b0000_0100,
		PH_RDUMMY = 8'b0000_1000,
		PH_RSTART = 8'b0001_0000,
		PH_RLEN   = 8'b0010_0000,
		PH_RDATA  = 8'b0100_0000,
		PH_RSUM   = 8'b1000_0000
	} phase_t;

	// job kinds passed from front to back
	typedef enum logic [2:0] {
		OP_WHDR,
		OP_WPAY,
		OP_RCMD,
		OP_POLL,
		OP_RDATA,
		OP_WDONE,
		OP_RDONE
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		logic [7:0] sum;
		logic       tail;
		logic [1:0] status;
		logic [7:0] count;
	} job_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_byte;
		logic       reply_wanted;
		logic [1:0] status;
		logic [7:0] byte_count;
		logic       last;
	} res_t;

	typedef logic [2:0] step_t;

	function automatic res_t tx_word(logic [7:0] b, logic rw, logic lst);
		res_t r;
		r.kind         = KIND_TX;
		r.out_byte     = b;
		r.reply_wanted = rw;
		r.status       = ST_OK;
		r.byte_count   = 8'd0;
		r.last         = lst;
		return r;
	endfunction

	// result word number k of a job
	function automatic res_t job_word(job_t j, step_t k);
		res_t r;
		r = tx_word(B_DUMMY, 1'b1, 1'b1);
		case (j.op)
			OP_WHDR: begin
				case (k)
					3'd0: r = tx_word(B_DC1, 1'b0, 1'b0);
					3'd1: r = tx_word(j.data, 1'b0, 1'b0);
					3'd2: r = tx_word(B_ESC, 1'b0, !j.tail);
					3'd3: r = tx_word(j.sum, 1'b0, 1'b0);
					default: r = tx_word(B_DUMMY, 1'b1, 1'b1);
				endcase
			end
			OP_WPAY: begin
				case (k)
					3'd0: r = tx_word(j.data, 1'b0, !j.tail);
					3'd1: r = tx_word(j.sum, 1'b0, 1'b0);
					default: r = tx_word(B_DUMMY, 1'b1, 1'b1);
				endcase
			end
			OP_RCMD: begin
				case (k)
					3'd0: r = tx_word(B_DC2, 1'b0, 1'b0);
					3'd1: r = tx_word(B_ONE, 1'b0, 1'b0);
					3'd2: r = tx_word(B_RD_CMD, 1'b0, 1'b0);
					3'd3: r = tx_word(B_RD_SUM, 1'b0, 1'b0);
					default: r = tx_word(B_DUMMY, 1'b1, 1'b1);
				endcase
			end
			OP_POLL: r = tx_word(B_DUMMY, 1'b1, 1'b1);
			OP_RDATA: begin
				if (k == 3'd0) begin
					r = tx_word(j.data, 1'b0, 1'b0);
					r.kind = KIND_RX;
				end else begin
					r = tx_word(B_DUMMY, 1'b1, 1'b1);
				end
			end
			OP_WDONE: begin
				r = tx_word(B_DUMMY, 1'b0, 1'b1);
				r.kind = KIND_WDONE;
				r.status = j.status;
			end
			OP_RDONE: begin
				r = tx_word(B_DUMMY, 1'b0, 1'b1);
				r.kind = KIND_RDONE;
				r.status = j.status;
				r.byte_count = j.count;
			end
			default: r = tx_word(B_DUMMY, 1'b1, 1'b1);
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/dfe_front.sv */
// front end: takes input words, tracks the link phase and sums, emits jobs
// depends on dfe_pkg
module dfe_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [1:0]         cmd,
	input  logic [7:0]         data_byte,
	input  logic [7:0]         frame_length,
	input  logic               buffer_ready,
	output logic               job_push,
	output dfe_pkg::job_t      job
);

	dfe_pkg::phase_t phase_q, phase_d;
	logic [7:0] sum_q, sum_d;
	logic [7:0] left_q, left_d;
	logic [7:0] size_q, size_d;
	logic       job_valid;
	logic [7:0] len;
	logic [7:0] sum_b;
	logic [7:0] left_m1;

	assign len     = frame_length + 8'd1;
	assign sum_b   = sum_q + data_byte;
	assign left_m1 = left_q - 8'd1;

	always_comb begin
		phase_d    = phase_q;
		sum_d      = sum_q;
		left_d     = left_q;
		size_d     = size_q;
		job_valid  = 1'b0;
		job.op     = dfe_pkg::OP_POLL;
		job.data   = data_byte;
		job.sum    = sum_q;
		job.tail   = 1'b0;
		job.status = dfe_pkg::ST_OK;
		job.count  = 8'd0;
		if (cmd == dfe_pkg::CMD_WR_START && phase_q == dfe_pkg::PH_IDLE) begin
			job_valid = 1'b1;
			job.op    = dfe_pkg::OP_WHDR;
			job.data  = len;
			sum_d     = dfe_pkg::B_DC1 + len + dfe_pkg::B_ESC;
			job.sum   = sum_d;
			job.tail  = (frame_length == 8'd0);
			left_d    = frame_length;
			phase_d   = (frame_length == 8'd0) ? dfe_pkg::PH_WACK : dfe_pkg::PH_WPAY;
		end else if (cmd == dfe_pkg::CMD_WR_BYTE && phase_q == dfe_pkg::PH_WPAY) begin
			job_valid = 1'b1;
			job.op    = dfe_pkg::OP_WPAY;
			job.sum   = sum_b;
			job.tail  = (left_m1 == 8'd0);
			sum_d     = sum_b;
			left_d    = left_m1;
			if (left_m1 == 8'd0) begin
				phase_d = dfe_pkg::PH_WACK;
			end
		end else if (cmd == dfe_pkg::CMD_RD_START && phase_q == dfe_pkg::PH_IDLE) begin
			job_valid = 1'b1;
			if (buffer_ready) begin
				job.op  = dfe_pkg::OP_RCMD;
				phase_d = dfe_pkg::PH_RDUMMY;
			end else begin
				job.op     = dfe_pkg::OP_RDONE;
				job.status = dfe_pkg::ST_NO_ACK;
			end
		end else if (cmd == dfe_pkg::CMD_REPLY) begin
			case (phase_q)
				dfe_pkg::PH_WACK: begin
					job_valid  = 1'b1;
					job.op     = dfe_pkg::OP_WDONE;
					job.status = (data_byte == dfe_pkg::B_ACK) ? dfe_pkg::ST_OK
					                                           : dfe_pkg::ST_NO_ACK;
					phase_d    = dfe_pkg::PH_IDLE;
				end
				dfe_pkg::PH_RDUMMY: begin
					job_valid = 1'b1;
					phase_d   = dfe_pkg::PH_RSTART;
				end
				dfe_pkg::PH_RSTART: begin
					job_valid = 1'b1;
					if (data_byte != dfe_pkg::B_DC1) begin
						job.op     = dfe_pkg::OP_RDONE;
						job.status = dfe_pkg::ST_BAD_SOF;
						phase_d    = dfe_pkg::PH_IDLE;
					end else begin
						sum_d   = dfe_pkg::B_DC1;
						phase_d = dfe_pkg::PH_RLEN;
					end
				end
				dfe_pkg::PH_RLEN: begin
					job_valid = 1'b1;
					size_d    = data_byte;
					left_d    = data_byte;
					sum_d     = sum_b;
					phase_d   = (data_byte == 8'd0) ? dfe_pkg::PH_RSUM : dfe_pkg::PH_RDATA;
				end
				dfe_pkg::PH_RDATA: begin
					job_valid = 1'b1;
					job.op    = dfe_pkg::OP_RDATA;
					sum_d     = sum_b;
					left_d    = left_m1;
					if (left_m1 == 8'd0) begin
						phase_d = dfe_pkg::PH_RSUM;
					end
				end
				dfe_pkg::PH_RSUM: begin
					job_valid = 1'b1;
					job.op    = dfe_pkg::OP_RDONE;
					if (data_byte == sum_q) begin
						job.status = dfe_pkg::ST_OK;
						job.count  = size_q;
					end else begin
						job.status = dfe_pkg::ST_BAD_SUM;
					end
					phase_d = dfe_pkg::PH_IDLE;
				end
				default: job_valid = 1'b0;
			endcase
		end
	end

	assign job_push = accept && job_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dfe_pkg::PH_IDLE;
			sum_q   <= 8'd0;
			left_q  <= 8'd0;
			size_q  <= 8'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			sum_q   <= sum_d;
			left_q  <= left_d;
			size_q  <= size_d;
		end
	end

endmodule

/* rtl/core/dfe_jobq.sv */
// two-entry job queue between front and back
// depends on dfe_pkg
module dfe_jobq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  dfe_pkg::job_t wr_job,
	output logic          full,
	input  logic          rd,
	output logic          head_valid,
	output dfe_pkg::job_t head
);

	dfe_pkg::job_t ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head       = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			ent_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

/* rtl/core/dfe_back.sv */
// back end: expands the head job into result words, one per cycle while the output register is free or being popped
// depends on dfe_pkg
module dfe_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  dfe_pkg::job_t head,
	output logic          job_pop,
	input  logic          pop,
	output logic          out_valid,
	output dfe_pkg::res_t res
);

	dfe_pkg::step_t step_q;
	dfe_pkg::res_t  res_q;
	dfe_pkg::res_t  word;
	logic           out_valid_q;
	logic           load;

	assign word      = dfe_pkg::job_word(head, step_q);
	assign load      = head_valid && (!out_valid_q || pop);
	assign job_pop   = load && word.last;
	assign out_valid = out_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				step_q      <= word.last ? 3'd0 : step_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/core/display_frame_engine_with_sum_check.sv */
// top level of the display link framer with 8-bit sum check
// depends on dfe_pkg, dfe_front, dfe_jobq, dfe_back
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+------------------------------------------------
//  input   | in        | push / full       | cmd, data_byte, frame_length, buffer_ready
//  result  | out       | pop / empty       | kind, out_byte, reply_wanted, status,
//          |           |                   | byte_count, last
//
// an input word is taken while the queue is not full; the front classifies it against the link
// phase and queues at most one job. the back turns a job into 1 to 5 result words at one word
// per cycle while the result register is free or being popped. the first word of an item passes
// through the job queue and the output register before it is on the result ports.
// arst_n clears the phase to idle, sums and counters to zero, and empties queue and output.
// a held result stalls the back; the two-job queue lets the front take words until it is full.
module display_frame_engine_with_sum_check (
	input  logic       clk,
	input  logic       arst_n,
	// input queue side
	input  logic       push,
	output logic       full,
	input  logic [1:0] cmd,
	input  logic [7:0] data_byte,
	input  logic [7:0] frame_length,
	input  logic       buffer_ready,
	// result queue side
	output logic       empty,
	input  logic       pop,
	output logic [1:0] kind,
	output logic [7:0] out_byte,
	output logic       reply_wanted,
	output logic [1:0] status,
	output logic [7:0] byte_count,
	output logic       last
);

	logic          accept;     // input word taken this edge
	logic          job_push;   // word produced results, queue a job
	dfe_pkg::job_t job;
	logic          q_full;
	logic          head_valid;
	dfe_pkg::job_t head;
	logic          job_pop;
	logic          out_valid;
	dfe_pkg::res_t res;

	assign full   = q_full;
	assign accept = push && !q_full;

	// phase tracking and job building
	dfe_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.cmd          (cmd),
		.data_byte    (data_byte),
		.frame_length (frame_length),
		.buffer_ready (buffer_ready),
		.job_push     (job_push),
		.job          (job)
	);

	// decouples the front from a stalled back
	dfe_jobq u_jobq (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (job_push),
		.wr_job     (job),
		.full       (q_full),
		.rd         (job_pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// word expansion and output register
	dfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.job_pop    (job_pop),
		.pop        (pop),
		.out_valid  (out_valid),
		.res        (res)
	);

	assign empty        = !out_valid;
	assign kind         = res.kind;
	assign out_byte     = res.out_byte;
	assign reply_wanted = res.reply_wanted;
	assign status       = res.status;
	assign byte_count   = res.byte_count;
	assign last         = res.last;

endmodule
